FILE: hw/rtl/mxb_pkg.sv
// mxb_pkg: shared types for the max-extract bag
// holds the controller/datapath command and status structs and the field widths
// no dependencies
package mxb_pkg;

  localparam int unsigned DATA_BITS  = 16;
  localparam int unsigned COUNT_BITS = 5;
  localparam int unsigned OUT_BITS   = 24;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  typedef struct packed {
    logic take;       // input transfer, capture op and value
    logic dispatch;   // decide insert / empty / start scan
    logic scan_step;  // advance read issue and compare stage
    logic remove;     // move last entry into freed slot
    logic load_out;   // load result into output register
  } cmd_t;

  typedef struct packed {
    logic op_extract;
    logic bag_empty;
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

FILE: hw/rtl/mxb_ctrl.sv
// mxb_ctrl: sequencing state machine of the max-extract bag
// drives cmd_t to the datapath and reads status_t back
// depends on mxb_pkg
module mxb_ctrl
  import mxb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    DISPATCH,
    SCAN,
    REMOVE,
    RESULT
  } state_t;

  state_t state;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd           = '0;
    cmd.take      = (state == IDLE) && in_valid;
    cmd.dispatch  = (state == DISPATCH);
    cmd.scan_step = (state == SCAN);
    cmd.remove    = (state == REMOVE);
    cmd.load_out  = (state == RESULT) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) state <= DISPATCH;
        end
        DISPATCH: begin
          if (status.op_extract && !status.bag_empty) state <= SCAN;
          else state <= RESULT;
        end
        SCAN: begin
          if (status.scan_done) state <= REMOVE;
        end
        REMOVE: begin
          state <= RESULT;
        end
        RESULT: begin
          if (status.out_free) state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/mxb_dp.sv
// mxb_dp: datapath of the max-extract bag
// entry memory, held count, one-comparator scan and the output register
// depends on mxb_pkg
module mxb_dp
  import mxb_pkg::*;
#(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_op,
  input  logic [DATA_BITS-1:0]  in_value,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_BITS-1:0]   out_data
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [VALUE_BITS-1:0] mem [CAPACITY];

  logic                  op;
  logic [VALUE_BITS-1:0] val;
  logic [CW-1:0]         count;
  logic [AW-1:0]         issue_addr;
  logic                  issuing;
  logic [VALUE_BITS-1:0] rd_data;
  logic [AW-1:0]         data_idx;
  logic                  data_vld;
  logic [VALUE_BITS-1:0] best;
  logic [AW-1:0]         best_idx;
  logic [DATA_BITS-1:0]  res_taken;
  logic                  res_empty;
  logic                  res_full;

  logic                  bag_full;
  logic                  bag_empty;
  logic [CW-1:0]         last_pos;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [VALUE_BITS-1:0] wdata;

  assign bag_full  = (count == CW'(CAPACITY));
  assign bag_empty = (count == '0);
  assign last_pos  = count - CW'(1);

  assign status.op_extract = (op == OP_EXTRACT);
  assign status.bag_empty  = bag_empty;
  assign status.scan_done  = data_vld && (CW'(data_idx) == last_pos);
  assign status.out_free   = !out_valid || out_ready;

  // rd_data of the final scan read is the last held entry
  assign we    = (cmd.dispatch && (op == OP_INSERT) && !bag_full) || cmd.remove;
  assign waddr = cmd.remove ? best_idx : count[AW-1:0];
  assign wdata = cmd.remove ? rd_data : val;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    // read only while issuing so the last entry stays on rd_data for the remove
    if (cmd.scan_step && issuing) rd_data <= mem[issue_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op  <= in_op;
      val <= VALUE_BITS'(in_value);
    end
    if (cmd.dispatch) begin
      res_taken  <= '0;
      res_empty  <= (op == OP_EXTRACT) && bag_empty;
      res_full   <= (op == OP_INSERT) && bag_full;
      issue_addr <= '0;
    end else if (cmd.scan_step && issuing) begin
      issue_addr <= issue_addr + AW'(1);
    end
    if (cmd.scan_step) begin
      data_idx <= issue_addr;
      // strict compare keeps the lowest index among equal maxima
      if (data_vld && ((data_idx == '0) || (best < rd_data))) begin
        best     <= rd_data;
        best_idx <= data_idx;
      end
    end
    if (cmd.remove) begin
      res_taken <= DATA_BITS'(best);
    end
    if (cmd.load_out) begin
      out_data <= {1'b0, COUNT_BITS'(count), res_full, res_empty, res_taken};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      issuing   <= 1'b0;
      data_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.dispatch) begin
        issuing  <= (op == OP_EXTRACT) && !bag_empty;
        data_vld <= 1'b0;
        if ((op == OP_INSERT) && !bag_full) count <= count + CW'(1);
      end else if (cmd.scan_step) begin
        data_vld <= issuing;
        if (issuing && (CW'(issue_addr) == last_pos)) issuing <= 1'b0;
      end
      if (cmd.remove) count <= last_pos;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("held count above capacity");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data[DATA_BITS] && out_data[DATA_BITS+1]))
    else $error("empty and full flagged together");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data[DATA_BITS]) |-> (out_data[DATA_BITS-1:0] == '0))
    else $error("empty extract returned nonzero value");

  a_remove_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.remove |-> !bag_empty)
    else $error("remove on empty bag");

endmodule

FILE: hw/rtl/max_extract_bag.sv
// max_extract_bag: bounded bag with largest-first extraction, one result per item
// insert or empty extract: DISPATCH, then RESULT loads the output register once it is free;
// extract of n held entries: DISPATCH, SCAN of all n entries, REMOVE, RESULT; the scan reads
// one entry a cycle through the single memory read port and one comparator
// the next item is taken only back in IDLE, after the last result has been loaded
// reset: synchronous, clears count and control; entry memory has no reset
module max_extract_bag
  import mxb_pkg::*;
#(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [DATA_BITS-1:0] s_tdata,   // value
  input  logic                 s_tuser,   // op
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_BITS-1:0]  m_tdata    // taken_value, was_empty, was_full, held_count
);

  cmd_t    cmd;
  status_t status;

  mxb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mxb_dp #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_op     (s_tuser),
    .in_value  (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
